// ----- rtl/atr_pkg.sv -----
// ----------------------------------------------------------------------------
// atr_pkg: shared types and constants for the average true range block
// Widths, controller states and the command/status records between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package atr_pkg;

	localparam int PRICE_W        = 32;
	localparam int CNT_W          = 7;
	localparam int WIN_MAX        = 127;
	localparam int SUM_W          = PRICE_W + CNT_W;
	localparam int FRAC_W         = 8;
	localparam int DIVD_W         = SUM_W + FRAC_W;
	localparam int AVG_W          = 40;
	localparam int STEP_W         = $clog2(DIVD_W);
	localparam int ATR_MAX_WINDOW = 64;
	localparam logic [CNT_W-1:0] WINDOW_RESET = CNT_W'(14);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TR,
		ST_SUB,
		ST_ADD,
		ST_DIV,
		ST_DONE
	} atr_state_t;

	typedef struct packed {
		logic ready;
		logic calc_tr;
		logic sub_old;
		logic add_new;
		logic div_step;
		logic finish;
	} atr_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic in_first;
		logic div_last;
		logic out_free;
	} atr_stat_t;

endpackage

// ----- rtl/atr_if.sv -----
// ----------------------------------------------------------------------------
// atr_if: bar input and average output channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface atr_in_if import atr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PRICE_W-1:0] bar_high;
	logic [PRICE_W-1:0] bar_low;
	logic [PRICE_W-1:0] bar_close;
	logic               first_bar;

	modport source (output valid, bar_high, bar_low, bar_close, first_bar, input ready);
	modport sink   (input valid, bar_high, bar_low, bar_close, first_bar, output ready);
endinterface

interface atr_out_if import atr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [AVG_W-1:0] range_average;
	logic [CNT_W-1:0] bars_averaged;

	modport source (output valid, range_average, bars_averaged, input ready);
	modport sink   (input valid, range_average, bars_averaged, output ready);
endinterface

// ----- rtl/atr_ram.sv -----
// ----------------------------------------------------------------------------
// atr_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module atr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/atr_ctrl.sv -----
// ----------------------------------------------------------------------------
// atr_ctrl: sequencing controller
// Steps one bar through true range, window update, division and output.
// ----------------------------------------------------------------------------
module atr_ctrl import atr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  atr_stat_t stat,
	output atr_cmd_t  cmd
);

	atr_state_t state_q;
	atr_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (stat.in_valid) begin
					state_nx = stat.in_first ? ST_DONE : ST_TR;
				end
			end
			ST_TR: begin
				cmd.calc_tr = 1'b1;
				state_nx    = ST_SUB;
			end
			ST_SUB: begin
				cmd.sub_old = 1'b1;
				state_nx    = ST_ADD;
			end
			ST_ADD: begin
				cmd.add_new = 1'b1;
				state_nx    = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_nx = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_nx   = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

endmodule

// ----- rtl/atr_datapath.sv -----
// ----------------------------------------------------------------------------
// atr_datapath: true range, ring window, running sum and radix-2 divider
// Holds the window register, the ring memory and the output register.
// ----------------------------------------------------------------------------
module atr_datapath import atr_pkg::*; #(
	parameter int MAX_WINDOW = ATR_MAX_WINDOW
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	atr_in_if.sink           bar_in,
	atr_out_if.source        avg_out,
	input  atr_cmd_t         cmd,
	output atr_stat_t        stat
);

	localparam int ADDR_W  = $clog2(MAX_WINDOW);
	localparam int WIN_CAP = (MAX_WINDOW > WIN_MAX) ? WIN_MAX : MAX_WINDOW;

	logic [CNT_W-1:0]   window_q;
	logic [PRICE_W-1:0] prev_close_q;
	logic [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]   filled_q;
	logic [CNT_W-1:0]   ptr_q;
	logic [STEP_W-1:0]  step_q;
	logic               out_valid_q;

	logic [PRICE_W-1:0] high_q;
	logic [PRICE_W-1:0] low_q;
	logic [PRICE_W-1:0] close_q;
	logic               first_q;
	logic [PRICE_W-1:0] tr_q;
	logic [DIVD_W-1:0]  div_q;
	logic [CNT_W-1:0]   rem_q;
	logic [AVG_W-1:0]   avg_q;
	logic [CNT_W-1:0]   cnt_q;

	logic [CNT_W-1:0]   win;
	logic [CNT_W-1:0]   ptr_adj;
	logic [CNT_W-1:0]   ptr_inc;
	logic [CNT_W:0]     ptr_sum;
	logic [PRICE_W-1:0] gap_hl;
	logic [PRICE_W-1:0] gap_hc;
	logic [PRICE_W-1:0] gap_lc;
	logic [PRICE_W-1:0] tr_nx;
	logic               full;
	logic [CNT_W:0]     rem_cat;
	logic               rem_ge;
	logic [CNT_W:0]     rem_sub;
	logic [SUM_W-1:0]   sum_new;
	logic [PRICE_W-1:0] old_tr;
	logic               accept;

	function automatic logic [PRICE_W-1:0] abs_gap(input logic [PRICE_W-1:0] a,
	                                               input logic [PRICE_W-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	assign accept = bar_in.valid && cmd.ready;

	always_comb begin
		if (window_q == '0) begin
			win = CNT_W'(1);
		end else if (window_q > CNT_W'(WIN_CAP)) begin
			win = CNT_W'(WIN_CAP);
		end else begin
			win = window_q;
		end
	end

	assign ptr_adj = (ptr_q >= win) ? '0 : ptr_q;
	assign ptr_sum = {1'b0, ptr_q} + (CNT_W+1)'(1);
	assign ptr_inc = (ptr_sum >= {1'b0, win}) ? '0 : ptr_sum[CNT_W-1:0];
	assign full    = (filled_q >= win);

	assign gap_hl = abs_gap(high_q, low_q);
	assign gap_hc = abs_gap(high_q, prev_close_q);
	assign gap_lc = abs_gap(low_q, prev_close_q);

	always_comb begin
		tr_nx = gap_hl;
		if (gap_hc > tr_nx) begin
			tr_nx = gap_hc;
		end
		if (gap_lc > tr_nx) begin
			tr_nx = gap_lc;
		end
	end

	assign sum_new = sum_q + SUM_W'(tr_q);
	assign rem_cat = {rem_q, div_q[DIVD_W-1]};
	assign rem_ge  = (rem_cat >= {1'b0, filled_q});
	assign rem_sub = rem_cat - {1'b0, filled_q};

	atr_ram #(
		.WIDTH (PRICE_W),
		.DEPTH (MAX_WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (cmd.add_new),
		.waddr (ADDR_W'(ptr_q)),
		.wdata (tr_q),
		.re    (cmd.calc_tr),
		.raddr (ADDR_W'(ptr_adj)),
		.rdata (old_tr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= WINDOW_RESET;
			prev_close_q <= '0;
			sum_q        <= '0;
			filled_q     <= '0;
			ptr_q        <= '0;
			step_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				window_q <= cfg_wdata;
				sum_q    <= '0;
				filled_q <= '0;
				ptr_q    <= '0;
			end
			if (cmd.calc_tr) begin
				prev_close_q <= close_q;
				ptr_q        <= ptr_adj;
			end
			if (cmd.sub_old) begin
				if (full) begin
					sum_q    <= sum_q - SUM_W'(old_tr);
					filled_q <= win;
				end else begin
					filled_q <= filled_q + CNT_W'(1);
				end
			end
			if (cmd.add_new) begin
				sum_q  <= sum_new;
				ptr_q  <= ptr_inc;
				step_q <= '0;
			end
			if (cmd.div_step) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				if (first_q) begin
					prev_close_q <= close_q;
					sum_q        <= '0;
					filled_q     <= '0;
					ptr_q        <= '0;
				end
			end else if (avg_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			high_q  <= bar_in.bar_high;
			low_q   <= bar_in.bar_low;
			close_q <= bar_in.bar_close;
			first_q <= bar_in.first_bar;
		end
		if (cmd.calc_tr) begin
			tr_q <= tr_nx;
		end
		if (cmd.add_new) begin
			div_q <= {sum_new, FRAC_W'(0)};
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			div_q <= {div_q[DIVD_W-2:0], rem_ge};
			rem_q <= rem_ge ? rem_sub[CNT_W-1:0] : rem_cat[CNT_W-1:0];
		end
		if (cmd.finish) begin
			avg_q <= first_q ? '0 : div_q[AVG_W-1:0];
			cnt_q <= first_q ? '0 : filled_q;
		end
	end

	assign bar_in.ready          = cmd.ready;
	assign avg_out.valid         = out_valid_q;
	assign avg_out.range_average = avg_q;
	assign avg_out.bars_averaged = cnt_q;

	assign stat.in_valid = bar_in.valid;
	assign stat.in_first = bar_in.first_bar;
	assign stat.div_last = (step_q == STEP_W'(DIVD_W - 1));
	assign stat.out_free = !out_valid_q || avg_out.ready;

endmodule

// ----- rtl/average_true_range.sv -----
// ----------------------------------------------------------------------------
// average_true_range: simple moving average of bar true ranges
// Steps: a first bar goes straight to the output register; any other bar
// passes through true range, subtract, add and 47 radix-2 divide steps.
// A new bar is taken only once the last is done; the divider is bit-serial.
// A word left waiting in the output register holds the next bar.
// Reset: asynchronous; window 14, window empty, previous close zero.
// ----------------------------------------------------------------------------
module average_true_range import atr_pkg::*; #(
	parameter int MAX_WINDOW = ATR_MAX_WINDOW
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	atr_in_if.sink           bar_in,
	atr_out_if.source        avg_out
);

	localparam int WIN_CAP = (MAX_WINDOW > WIN_MAX) ? WIN_MAX : MAX_WINDOW;

	atr_cmd_t  cmd;
	atr_stat_t stat;

	atr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	atr_datapath #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.bar_in    (bar_in),
		.avg_out   (avg_out),
		.cmd       (cmd),
		.stat      (stat)
	);

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("controller issued more than one command");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(bar_in.valid && bar_in.ready) |=> !bar_in.ready)
		else $error("input taken while a bar is in progress");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		avg_out.valid |-> (avg_out.bars_averaged <= CNT_W'(WIN_CAP)))
		else $error("bars averaged above window cap");

	a_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		(avg_out.valid && avg_out.bars_averaged == '0) |-> (avg_out.range_average == '0))
		else $error("nonzero average with empty window");

endmodule

// ----- bench/atr_checker.sv -----
// ----------------------------------------------------------------------------
// atr_checker: result checker for the average true range block
// Watches the configuration port and both channels. Keeps its own copy of the
// window, previous close, true range history and running sum. It predicts one
// average word per accepted bar and compares each output word, field by
// field, with the oldest prediction.
// ----------------------------------------------------------------------------
module atr_checker import atr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	atr_in_if                bar_mon,
	atr_out_if               avg_mon,
	output int               fail_count,
	output int               open_count
);

	typedef struct packed {
		logic [AVG_W-1:0] range_average;
		logic [CNT_W-1:0] bars_averaged;
	} atr_result_t;

	atr_result_t        expected_averages [$];
	logic [CNT_W-1:0]   window_length;
	logic [PRICE_W-1:0] last_close;
	logic [PRICE_W-1:0] range_hist [ATR_MAX_WINDOW];
	logic [SUM_W-1:0]   range_total;
	logic [CNT_W-1:0]   ranges_held;
	int unsigned        slot;

	function automatic logic [PRICE_W-1:0] gap_of(input logic [PRICE_W-1:0] a,
			input logic [PRICE_W-1:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	function automatic int unsigned window_in_use();
		if (window_length == '0)
			return 1;
		if (window_length > ATR_MAX_WINDOW)
			return ATR_MAX_WINDOW;
		return 32'(window_length);
	endfunction

	function automatic void clear_window();
		range_total = '0;
		ranges_held = '0;
		slot        = 0;
	endfunction

	function automatic atr_result_t predict_bar(input logic [PRICE_W-1:0] hi,
			input logic [PRICE_W-1:0] lo, input logic [PRICE_W-1:0] cl, input logic first);
		logic [PRICE_W-1:0] tr;
		int unsigned        w;
		logic [DIVD_W-1:0]  scaled;
		atr_result_t        r;
		if (first) begin
			last_close = cl;
			clear_window();
			return '0;
		end
		tr = gap_of(hi, lo);
		if (gap_of(hi, last_close) > tr)
			tr = gap_of(hi, last_close);
		if (gap_of(lo, last_close) > tr)
			tr = gap_of(lo, last_close);
		w = window_in_use();
		if (slot >= w)
			slot = 0;
		// oldest range drops out only once the window is full
		if (ranges_held >= w) begin
			range_total = range_total - SUM_W'(range_hist[slot]);
			ranges_held = CNT_W'(w);
		end else begin
			ranges_held = ranges_held + CNT_W'(1);
		end
		range_hist[slot] = tr;
		range_total      = range_total + SUM_W'(tr);
		slot             = (slot + 1 >= w) ? 0 : slot + 1;
		last_close       = cl;
		scaled           = {range_total, {FRAC_W{1'b0}}};
		r.range_average  = AVG_W'(scaled / DIVD_W'(ranges_held));
		r.bars_averaged  = ranges_held;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		atr_result_t seen;
		atr_result_t want;
		if (!arst_n) begin
			window_length = WINDOW_RESET;
			last_close    = '0;
			clear_window();
			expected_averages.delete();
			open_count <= 0;
		end else begin
			if (cfg_we) begin
				window_length = cfg_wdata;
				clear_window();
			end
			if (avg_mon.valid && avg_mon.ready) begin
				seen.range_average = avg_mon.range_average;
				seen.bars_averaged = avg_mon.bars_averaged;
				if (expected_averages.size() == 0) begin
					$error("unexpected word: range_average %0h bars_averaged %0d",
						seen.range_average, seen.bars_averaged);
					fail_count = fail_count + 1;
				end else begin
					want = expected_averages.pop_front();
					if (seen.range_average !== want.range_average) begin
						$error("range_average: expected %0h actual %0h",
							want.range_average, seen.range_average);
						fail_count = fail_count + 1;
					end
					if (seen.bars_averaged !== want.bars_averaged) begin
						$error("bars_averaged: expected %0d actual %0d",
							want.bars_averaged, seen.bars_averaged);
						fail_count = fail_count + 1;
					end
				end
			end
			if (bar_mon.valid && bar_mon.ready)
				expected_averages = {expected_averages, predict_bar(bar_mon.bar_high,
					bar_mon.bar_low, bar_mon.bar_close, bar_mon.first_bar)};
			open_count <= expected_averages.size();
		end
	end

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for the average true range block
// Drives a short directed run of extreme bars, then bar series with random
// walks, noise and full-span bars across several window settings, with random
// gaps on the bar side and random stalls on the average side. A checker
// beside the block predicts and compares every average word.
// ----------------------------------------------------------------------------
module tb_top;
	import atr_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_BARS  = 75;
	localparam int DRAIN_WAIT  = 80;
	localparam logic [PRICE_W-1:0] PRICE_TOP = '1;
	localparam logic [CNT_W-1:0] WINDOW_PLAN [8] =
		'{7'd0, 7'd1, 7'd2, 7'd64, 7'd65, 7'd127, 7'd5, 7'd14};

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;
	logic             src_steady;
	int               fail_count;
	int               open_count;
	int unsigned      cycle_count = 0;

	atr_in_if  bar_in  ();
	atr_out_if avg_out ();

	average_true_range i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.bar_in    (bar_in),
		.avg_out   (avg_out)
	);

	atr_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.bar_mon    (bar_in),
		.avg_mon    (avg_out),
		.fail_count (fail_count),
		.open_count (open_count)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	function automatic logic [PRICE_W-1:0] rand_price();
		case ($urandom_range(0, 7))
			0: begin
				return '0;
			end
			1: begin
				return PRICE_TOP;
			end
			2: begin
				return PRICE_W'($urandom_range(0, 255));
			end
			3: begin
				return PRICE_TOP - PRICE_W'($urandom_range(0, 255));
			end
			default: begin
				return $urandom();
			end
		endcase
	endfunction

	function automatic longint jitter(input longint mag);
		return longint'({$urandom()} % (mag + 1));
	endfunction

	function automatic logic [PRICE_W-1:0] clamp_price(input longint v);
		if (v < 0)
			return '0;
		if (v > 64'sh0000_0000_FFFF_FFFF)
			return PRICE_TOP;
		return v[PRICE_W-1:0];
	endfunction

	task automatic send_bar(input logic [PRICE_W-1:0] hi, input logic [PRICE_W-1:0] lo,
			input logic [PRICE_W-1:0] cl, input logic first);
		int gap;
		if ($urandom_range(0, 39) == 0)
			src_steady = !src_steady;
		gap = src_steady ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			bar_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		bar_in.valid     <= 1'b1;
		bar_in.bar_high  <= hi;
		bar_in.bar_low   <= lo;
		bar_in.bar_close <= cl;
		bar_in.first_bar <= first;
		@(posedge clk);
		while (!(bar_in.valid && bar_in.ready)) @(posedge clk);
	endtask

	task automatic settle();
		bar_in.valid <= 1'b0;
		do @(posedge clk); while (open_count != 0);
	endtask

	task automatic write_window(input logic [CNT_W-1:0] w);
		cfg_we    <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin : result_sink
		int   stall;
		logic steady;
		avg_out.ready = 1'b0;
		steady        = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				steady = !steady;
			stall = steady ? 0 : $urandom_range(0, 19);
			if (stall != 0) begin
				avg_out.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			avg_out.ready <= 1'b1;
			@(posedge clk);
			while (!(avg_out.valid && avg_out.ready)) @(posedge clk);
		end
	end

	initial begin : stimulus
		int                 series_left;
		int                 kind;
		longint             mag;
		longint             mid;
		logic [PRICE_W-1:0] walk;
		logic [PRICE_W-1:0] hi_v;
		logic [PRICE_W-1:0] lo_v;
		logic [PRICE_W-1:0] cl_v;
		logic               first_v;
		logic [CNT_W-1:0]   win;
		bar_in.valid     = 1'b0;
		bar_in.bar_high  = '0;
		bar_in.bar_low   = '0;
		bar_in.bar_close = '0;
		bar_in.first_bar = 1'b0;
		src_steady       = 1'b0;
		series_left      = 0;
		mag              = 15;
		walk             = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset window of 14; first bar ever is not marked first
		send_bar(32'd100, 32'd50, 32'd70, 1'b0);
		send_bar(PRICE_TOP, PRICE_TOP, PRICE_TOP, 1'b1);
		send_bar(PRICE_TOP, '0, PRICE_TOP, 1'b0);
		send_bar('0, '0, '0, 1'b0);
		send_bar(32'd10, 32'd1000, 32'd500, 1'b0);
		send_bar(PRICE_TOP, PRICE_TOP, PRICE_TOP, 1'b0);
		send_bar('0, '0, '0, 1'b1);
		send_bar('0, '0, '0, 1'b1);
		send_bar(32'd5, 32'd5, 32'd5, 1'b0);
		send_bar(PRICE_TOP, PRICE_TOP - 1'b1, 32'd3, 1'b0);
		send_bar('0, PRICE_TOP, '0, 1'b0);
		// full-span ranges, enough to wrap the window
		repeat (12) send_bar(PRICE_TOP, '0, $urandom(), 1'b0);

		for (int phase = 0; phase < 8; phase++) begin
			settle();
			win = (phase == 6) ? CNT_W'($urandom_range(3, 63)) : WINDOW_PLAN[phase];
			write_window(win);
			for (int n = 0; n < PHASE_BARS; n++) begin
				if (series_left == 0) begin
					series_left = $urandom_range(1, 140);
					case ($urandom_range(0, 3))
						0: mag = 15;
						1: mag = 4095;
						2: mag = 1 << 20;
						default: mag = 64'h0000_0000_FFFF_FFFF;
					endcase
					if ($urandom_range(0, 9) != 0) begin
						walk = rand_price();
						send_bar(rand_price(), rand_price(), walk, 1'b1);
						continue;
					end
				end
				series_left--;
				kind = $urandom_range(0, 99);
				if (kind < 6) begin
					first_v = ($urandom_range(0, 3) == 0);
					walk    = rand_price();
					send_bar(rand_price(), rand_price(), walk, first_v);
				end else if (kind < 10) begin
					walk = rand_price();
					send_bar(PRICE_TOP, '0, walk, 1'b0);
				end else begin
					mid  = longint'(walk) + jitter(mag) - jitter(mag);
					hi_v = clamp_price(mid + jitter(mag));
					lo_v = clamp_price(mid - jitter(mag));
					if (hi_v < lo_v)
						hi_v = lo_v;
					cl_v = lo_v + PRICE_W'({$urandom()} % (longint'(hi_v) - longint'(lo_v) + 1));
					walk = cl_v;
					send_bar(hi_v, lo_v, cl_v, 1'b0);
				end
			end
		end

		settle();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/atr_pkg.sv
rtl/atr_if.sv
rtl/atr_ram.sv
rtl/atr_ctrl.sv
rtl/atr_datapath.sv
rtl/average_true_range.sv
bench/atr_checker.sv
bench/tb_top.sv
